/* design/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and helpers for the matrix vector transform
// Element, vector and matrix types, operating modes, lane control and the
// 32-bit saturation used by the merge stage.
// ----------------------------------------------------------------------------
package mvt_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DIM    = 4;
   localparam int ELEM_W = 32;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [PAIR_W-1:0] pair_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

   typedef elem_type vec4_type [DIM];
   typedef vec4_type mat_type [DIM];
   typedef pair_type pair2_type [2];

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_XFORM  = 2'd1,
      MODE_INVERT = 2'd2
   } mode_type;

   typedef struct packed {
      logic adv1;   // capture products
      logic adv2;   // capture pair sums
   } lane_ctrl_type;

   localparam sum_type ELEM_MAX = {{(SUM_W-ELEM_W+1){1'b0}}, {(ELEM_W-1){1'b1}}};
   localparam sum_type ELEM_MIN = {{(SUM_W-ELEM_W+1){1'b1}}, {(ELEM_W-1){1'b0}}};

   function automatic elem_type sat32(input sum_type v);
      elem_type r;
      if (v > ELEM_MAX) begin
         r = ELEM_MAX[ELEM_W-1:0];
      end else if (v < ELEM_MIN) begin
         r = ELEM_MIN[ELEM_W-1:0];
      end else begin
         r = v[ELEM_W-1:0];
      end
      return r;
   endfunction

endpackage

/* design/mvt_if.sv */
// ----------------------------------------------------------------------------
// mvt_if: request and response channels
// Valid/ready channels carrying the request item and the result item.
// ----------------------------------------------------------------------------
interface mvt_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [1:0]          row_index;
   mvt_pkg::elem_type   elem_x;
   mvt_pkg::elem_type   elem_y;
   mvt_pkg::elem_type   elem_z;
   mvt_pkg::elem_type   elem_w;

   modport source (output valid, mode, row_index, elem_x, elem_y, elem_z, elem_w,
                   input ready);
   modport sink   (input valid, mode, row_index, elem_x, elem_y, elem_z, elem_w,
                   output ready);
endinterface

interface mvt_rsp_if;
   logic                valid;
   logic                ready;
   mvt_pkg::elem_type   out_x;
   mvt_pkg::elem_type   out_y;
   mvt_pkg::elem_type   out_z;
   mvt_pkg::elem_type   out_w;

   modport source (output valid, out_x, out_y, out_z, out_w, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_w, output ready);
endinterface

/* design/matrix_vector_transform.sv */
// ----------------------------------------------------------------------------
// matrix_vector_transform: 4x4 fixed-point matrix vector transform
// Holds a 4x4 Q16.16 matrix; loads rows, transforms row vectors, and
// replaces the matrix by its rigid quick inverse.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries mode, row_index and four elements; rsp_chan carries the
//   four transformed components. A transfer happens when valid and ready are
//   both high at a rising clock edge.
//   Load row (mode 0) writes the matrix at the transfer; the next item sees
//   it. Transform (mode 1) gives one result per item and sustains one item
//   per cycle while the receiver keeps up: four column lanes each run a
//   multiply stage and a pair-add stage, and the merge stage sums, shifts
//   and saturates into the output register.
//   Quick invert (mode 2) runs through the same lanes and commits once its
//   pair sums are registered; req_chan.ready stays low until then. Mode 3
//   and load give no result.
//   A stalled receiver holds the output register; the two pipeline stages
//   fill behind it before req_chan.ready drops.
//   Reset sets the matrix to identity and empties the pipeline.
// ----------------------------------------------------------------------------
module matrix_vector_transform #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mvt_req_if.sink   req_chan,
   mvt_rsp_if.source rsp_chan
);

   mvt_pkg::mat_type       mat;
   mvt_pkg::vec4_type      vec;
   mvt_pkg::vec4_type      op_a [mvt_pkg::DIM];
   mvt_pkg::vec4_type      op_b [mvt_pkg::DIM];
   mvt_pkg::pair2_type     lane_pair [mvt_pkg::DIM];
   mvt_pkg::vec4_type      res;
   mvt_pkg::vec4_type      inv_row;
   mvt_pkg::lane_ctrl_type lane_ctrl;
   mvt_pkg::mode_type      mode;

   logic s1_valid_ff, s1_valid_in, s1_inv_ff, s1_inv_in;
   logic s2_valid_ff, s2_valid_in, s2_inv_ff, s2_inv_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic pend_ff, pend_in;
   logic ready1, ready2, rsp_free, accept, push, is_inv, load_en, commit;

   assign mode = mvt_pkg::mode_type'(req_chan.mode);
   assign vec[0] = req_chan.elem_x;
   assign vec[1] = req_chan.elem_y;
   assign vec[2] = req_chan.elem_z;
   assign vec[3] = req_chan.elem_w;

   // operand select: transform uses vector x column, invert uses
   // translation row x rotation row of the lane
   always_comb begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
         for (int r = 0; r < mvt_pkg::DIM; r++) begin
            if (is_inv) begin
               op_a[c][r] = (r < mvt_pkg::DIM - 1) ? mat[mvt_pkg::DIM-1][r] : '0;
               op_b[c][r] = (r < mvt_pkg::DIM - 1) ? mat[c][r] : '0;
            end else begin
               op_a[c][r] = vec[r];
               op_b[c][r] = mat[r][c];
            end
         end
      end
   end

   always_comb begin
      is_inv  = 1'b0;
      push    = 1'b0;
      load_en = 1'b0;
      case (mode)
         mvt_pkg::MODE_LOAD: begin
            load_en = 1'b1;
         end
         mvt_pkg::MODE_XFORM: begin
            push = 1'b1;
         end
         mvt_pkg::MODE_INVERT: begin
            push   = 1'b1;
            is_inv = 1'b1;
         end
         default: begin
            push = 1'b0;
         end
      endcase

      rsp_free = !rsp_valid_ff || rsp_chan.ready;
      ready2   = !s2_valid_ff || s2_inv_ff || rsp_free;
      ready1   = !s1_valid_ff || ready2;
      commit   = s2_valid_ff && s2_inv_ff;
      accept   = req_chan.valid && ready1 && !pend_ff;

      lane_ctrl.adv1 = accept && push;
      lane_ctrl.adv2 = ready2 && s1_valid_ff;

      s1_valid_in  = ready1 ? (accept && push) : s1_valid_ff;
      s1_inv_in    = ready1 ? is_inv : s1_inv_ff;
      s2_valid_in  = ready2 ? s1_valid_ff : s2_valid_ff;
      s2_inv_in    = ready2 ? s1_inv_ff : s2_inv_ff;
      rsp_valid_in = rsp_free ? (s2_valid_ff && !s2_inv_ff) : rsp_valid_ff;

      // hold off new items until the inverted matrix is written
      pend_in = pend_ff;
      if (commit) begin
         pend_in = 1'b0;
      end else if (accept && is_inv) begin
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_inv_ff    <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s2_inv_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s1_inv_ff    <= s1_inv_in;
         s2_valid_ff  <= s2_valid_in;
         s2_inv_ff    <= s2_inv_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   mvt_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .load_en  (accept && load_en),
      .load_row (req_chan.row_index),
      .load_vec (vec),
      .commit   (commit),
      .inv_row  (inv_row),
      .mat_ff   (mat)
   );

   for (genvar c = 0; c < mvt_pkg::DIM; c++) begin : g_lane
      mvt_lane u_lane (
         .clock   (clock),
         .ctrl    (lane_ctrl),
         .op_a    (op_a[c]),
         .op_b    (op_b[c]),
         .pair_ff (lane_pair[c])
      );
   end

   mvt_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock     (clock),
      .capture   (rsp_free && s2_valid_ff && !s2_inv_ff),
      .lane_pair (lane_pair),
      .res_ff    (res),
      .inv_row   (inv_row)
   );

   assign req_chan.ready = ready1 && !pend_ff;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.out_x = res[0];
   assign rsp_chan.out_y = res[1];
   assign rsp_chan.out_z = res[2];
   assign rsp_chan.out_w = res[3];

endmodule

/* design/mvt_lane.sv */
// ----------------------------------------------------------------------------
// mvt_lane: one column lane
// Four signed 32x32 products, registered, then two registered pair sums.
// ----------------------------------------------------------------------------
module mvt_lane (
   input  logic                   clock,
   input  mvt_pkg::lane_ctrl_type ctrl,
   input  mvt_pkg::vec4_type      op_a,
   input  mvt_pkg::vec4_type      op_b,
   output mvt_pkg::pair2_type     pair_ff
);

   mvt_pkg::prod_type  prod_ff [mvt_pkg::DIM];
   mvt_pkg::prod_type  prod_in [mvt_pkg::DIM];
   mvt_pkg::pair2_type pair_in;

   always_comb begin
      for (int k = 0; k < mvt_pkg::DIM; k++) begin
         prod_in[k] = op_a[k] * op_b[k];
      end
      pair_in[0] = mvt_pkg::PAIR_W'(prod_ff[0]) + mvt_pkg::PAIR_W'(prod_ff[1]);
      pair_in[1] = mvt_pkg::PAIR_W'(prod_ff[2]) + mvt_pkg::PAIR_W'(prod_ff[3]);
   end

   always_ff @(posedge clock) begin
      if (ctrl.adv1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.adv2) begin
         pair_ff <= pair_in;
      end
   end

endmodule

/* design/mvt_merge.sv */
// ----------------------------------------------------------------------------
// mvt_merge: lane merge stage
// Finishes each lane's dot product, floor-shifts and saturates it, and
// registers the result item; also yields the negated row for quick invert.
// ----------------------------------------------------------------------------
module mvt_merge #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               capture,
   input  mvt_pkg::pair2_type lane_pair [mvt_pkg::DIM],
   output mvt_pkg::vec4_type  res_ff,
   output mvt_pkg::vec4_type  inv_row
);

   mvt_pkg::sum_type  total [mvt_pkg::DIM];
   mvt_pkg::sum_type  shifted [mvt_pkg::DIM];
   mvt_pkg::vec4_type res_in;

   always_comb begin
      for (int c = 0; c < mvt_pkg::DIM; c++) begin
         total[c]   = mvt_pkg::SUM_W'(lane_pair[c][0]) + mvt_pkg::SUM_W'(lane_pair[c][1]);
         shifted[c] = total[c] >>> FRAC_BITS;
         res_in[c]  = mvt_pkg::sat32(shifted[c]);
         inv_row[c] = mvt_pkg::sat32(-shifted[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (capture) begin
         res_ff <= res_in;
      end
   end

endmodule

/* design/mvt_matrix.sv */
// ----------------------------------------------------------------------------
// mvt_matrix: held 4x4 matrix
// Row-major store, identity after reset; row load and quick-invert commit.
// ----------------------------------------------------------------------------
module mvt_matrix #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              load_en,
   input  logic [1:0]        load_row,
   input  mvt_pkg::vec4_type load_vec,
   input  logic              commit,
   input  mvt_pkg::vec4_type inv_row,
   output mvt_pkg::mat_type  mat_ff
);

   localparam mvt_pkg::elem_type UNIT = mvt_pkg::elem_type'(1) << FRAC_BITS;

   mvt_pkg::mat_type inv_mat;

   always_comb begin
      for (int r = 0; r < mvt_pkg::DIM - 1; r++) begin
         for (int c = 0; c < mvt_pkg::DIM - 1; c++) begin
            inv_mat[r][c] = mat_ff[c][r];
         end
         inv_mat[r][mvt_pkg::DIM-1] = '0;
         inv_mat[mvt_pkg::DIM-1][r] = inv_row[r];
      end
      inv_mat[mvt_pkg::DIM-1][mvt_pkg::DIM-1] = UNIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < mvt_pkg::DIM; r++) begin
            for (int c = 0; c < mvt_pkg::DIM; c++) begin
               mat_ff[r][c] <= (r == c) ? UNIT : '0;
            end
         end
      end else if (commit) begin
         mat_ff <= inv_mat;
      end else if (load_en) begin
         mat_ff[load_row] <= load_vec;
      end
   end

endmodule

/* test/matrix_vector_transform_test.sv */
// ----------------------------------------------------------------------------
// matrix_vector_transform_test: self-checking bench for the matrix transform
// Drives row loads, vector transforms, quick inverts and unused-mode items
// through the request channel. A shadow copy of the held matrix predicts
// every transformed vector, which is compared field by field with the
// response channel. Sender and receiver idle at random in the first two of
// three phases; in the third the receiver holds off to back up the pipeline.
// ----------------------------------------------------------------------------
module matrix_vector_transform_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int                FRAC        = mvt_pkg::FRAC_BITS_DEFAULT;
   localparam logic [1:0]        MODE_UNUSED = 2'd3;
   localparam mvt_pkg::elem_type Q_ONE       = 32'sd65536;
   localparam mvt_pkg::elem_type E_MAX       = 32'sh7FFFFFFF;
   localparam mvt_pkg::elem_type E_MIN       = 32'sh80000000;
   localparam logic signed [67:0] WIDE_MAX = 68'sd2147483647;
   localparam logic signed [67:0] WIDE_MIN = -68'sd2147483648;
   localparam int          RANDOM_ITEMS = 800;
   localparam int          HOLD_CYCLES  = 90;
   localparam int          CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [1:0]        mode;
      logic [1:0]        row;
      mvt_pkg::elem_type x;
      mvt_pkg::elem_type y;
      mvt_pkg::elem_type z;
      mvt_pkg::elem_type w;
      bit                drain;
   } vertex_req_type;

   typedef struct packed {
      mvt_pkg::elem_type x;
      mvt_pkg::elem_type y;
      mvt_pkg::elem_type z;
      mvt_pkg::elem_type w;
   } vertex_out_type;

   logic clock = 1'b0;
   logic reset;

   mvt_req_if req_chan ();
   mvt_rsp_if rsp_chan ();

   matrix_vector_transform uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   vertex_req_type    vertex_backlog [$];
   vertex_out_type    transformed_due [$];
   mvt_pkg::elem_type matrix_shadow [4][4];

   vertex_req_type on_wire;
   vertex_out_type fresh_out;
   vertex_out_type want_out;
   bit             fresh_valid;
   int             due_next;

   int n_items       = 0;
   int items_taken   = 0;
   int results_due   = 0;
   int results_seen  = 0;
   int failures      = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;
   int traffic_phase;

   assign traffic_phase = (items_taken < n_items / 3)     ? 0 :
                          (items_taken < 2 * n_items / 3) ? 1 : 2;

   function automatic mvt_pkg::elem_type clamp_elem(input logic signed [67:0] v);
      if (v > WIDE_MAX) begin
         return E_MAX;
      end else if (v < WIDE_MIN) begin
         return E_MIN;
      end
      return v[31:0];
   endfunction

   function automatic mvt_pkg::elem_type rand_elem();
      case ($urandom_range(9))
         0: begin
            return E_MAX;
         end
         1: begin
            return E_MIN;
         end
         2, 3, 4, 5: begin
            return mvt_pkg::elem_type'($urandom_range(524288)) - 32'sd262144;
         end
         6: begin
            return Q_ONE * mvt_pkg::elem_type'($urandom_range(4)) - 2 * Q_ONE;
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   // Apply one accepted item to the shadow matrix; flag a result for transforms.
   task automatic apply_to_shadow(input vertex_req_type it, output bit has_out,
                                  output vertex_out_type res);
      logic signed [67:0] acc;
      logic signed [67:0] a;
      logic signed [67:0] b;
      mvt_pkg::elem_type vec [4];
      mvt_pkg::elem_type comp [4];
      mvt_pkg::elem_type inv [4][4];
      int r;
      int c;
      has_out = 1'b0;
      res = '0;
      vec[0] = it.x;
      vec[1] = it.y;
      vec[2] = it.z;
      vec[3] = it.w;
      case (it.mode)
         mvt_pkg::MODE_LOAD: begin
            for (c = 0; c < 4; c++) matrix_shadow[it.row][c] = vec[c];
         end
         mvt_pkg::MODE_XFORM: begin
            for (c = 0; c < 4; c++) begin
               acc = '0;
               for (r = 0; r < 4; r++) begin
                  a = vec[r];
                  b = matrix_shadow[r][c];
                  acc = acc + a * b;
               end
               comp[c] = clamp_elem(acc >>> FRAC);
            end
            res = '{comp[0], comp[1], comp[2], comp[3]};
            has_out = 1'b1;
         end
         mvt_pkg::MODE_INVERT: begin
            for (r = 0; r < 3; r++) begin
               for (c = 0; c < 3; c++) inv[r][c] = matrix_shadow[c][r];
               inv[r][3] = '0;
            end
            // translation: negate after the floor shift of the exact sum
            for (c = 0; c < 3; c++) begin
               acc = '0;
               for (r = 0; r < 3; r++) begin
                  a = matrix_shadow[3][r];
                  b = inv[r][c];
                  acc = acc + a * b;
               end
               inv[3][c] = clamp_elem(-(acc >>> FRAC));
            end
            inv[3][3] = Q_ONE;
            for (r = 0; r < 4; r++)
               for (c = 0; c < 4; c++) matrix_shadow[r][c] = inv[r][c];
         end
         default: begin
         end
      endcase
   endtask

   function automatic void queue_vertex(input logic [1:0] mode, input logic [1:0] row,
                                        input mvt_pkg::elem_type x,
                                        input mvt_pkg::elem_type y,
                                        input mvt_pkg::elem_type z,
                                        input mvt_pkg::elem_type w,
                                        input bit drain);
      vertex_req_type it;
      it.mode  = mode;
      it.row   = row;
      it.x     = x;
      it.y     = y;
      it.z     = z;
      it.w     = w;
      it.drain = drain;
      vertex_backlog.push_back(it);
   endfunction

   task automatic check_field(input string name, input mvt_pkg::elem_type want,
                              input mvt_pkg::elem_type got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         due_next = results_due;
         if (req_chan.valid && req_chan.ready) begin
            apply_to_shadow(on_wire, fresh_valid, fresh_out);
            if (fresh_valid) begin
               transformed_due.push_back(fresh_out);
               due_next = results_due + 1;
            end
            results_due <= due_next;
            items_taken <= items_taken + 1;
         end
         // hold the item until its transfer
         if (!req_chan.valid || req_chan.ready) begin
            if (vertex_backlog.size() > 0 &&
                !(vertex_backlog[0].drain && due_next != results_seen) &&
                $urandom_range(99) >= (traffic_phase == 0 ? 36 :
                                       traffic_phase == 1 ? 79 : 0)) begin
               on_wire = vertex_backlog.pop_front();
               req_chan.valid     <= 1'b1;
               req_chan.mode      <= on_wire.mode;
               req_chan.row_index <= on_wire.row;
               req_chan.elem_x    <= on_wire.x;
               req_chan.elem_y    <= on_wire.y;
               req_chan.elem_z    <= on_wire.z;
               req_chan.elem_w    <= on_wire.w;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (transformed_due.size() == 0) begin
               $error("unexpected result: %0d %0d %0d %0d", rsp_chan.out_x,
                      rsp_chan.out_y, rsp_chan.out_z, rsp_chan.out_w);
               failures++;
            end else begin
               want_out = transformed_due.pop_front();
               check_field("out_x", want_out.x, rsp_chan.out_x);
               check_field("out_y", want_out.y, rsp_chan.out_y);
               check_field("out_z", want_out.z, rsp_chan.out_z);
               check_field("out_w", want_out.w, rsp_chan.out_w);
               results_seen <= results_seen + 1;
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && items_taken >= 2 * n_items / 3 + 30) begin
            // back up the pipeline while the sender keeps offering
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= $urandom_range(99) >= (traffic_phase == 0 ? 79 :
                                                     traffic_phase == 1 ? 36 : 0);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int pick;
      int burst;
      int count;
      int r;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.mode      = mvt_pkg::MODE_LOAD;
      req_chan.row_index = 2'd0;
      req_chan.elem_x    = '0;
      req_chan.elem_y    = '0;
      req_chan.elem_z    = '0;
      req_chan.elem_w    = '0;
      rsp_chan.ready     = 1'b0;
      for (r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) matrix_shadow[r][c] = (r == c) ? Q_ONE : '0;

      // identity after reset, row index ignored, unused mode changes nothing
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, E_MAX, E_MIN, 32'sd0, -32'sd1, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd3, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
      queue_vertex(MODE_UNUSED, 2'd2, E_MAX, E_MAX, E_MAX, E_MAX, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd1, Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE, 1'b0);
      // saturation both ways
      for (r = 0; r < 4; r++)
         queue_vertex(mvt_pkg::MODE_LOAD, r[1:0], E_MAX, E_MAX, E_MAX, E_MAX, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, E_MAX, E_MAX, E_MAX, E_MAX, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
      for (r = 0; r < 4; r++)
         queue_vertex(mvt_pkg::MODE_LOAD, r[1:0], E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd2, E_MIN, E_MIN, E_MIN, E_MIN, 1'b0);
      // floor rounding of a negative sum
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd0, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b1);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, -32'sd1, 32'sd0, 32'sd0, 32'sd0, 1'b0);
      // rigid transform and its quick inverse
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd0, 32'sd0, Q_ONE, 32'sd0, 32'sd0, 1'b0);
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd1, -Q_ONE, 32'sd0, 32'sd0, 32'sd0, 1'b0);
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd2, 32'sd0, 32'sd0, Q_ONE, 32'sd0, 1'b0);
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd3, 3 * Q_ONE, -5 * Q_ONE, 7 * Q_ONE, Q_ONE,
                   1'b0);
      queue_vertex(mvt_pkg::MODE_INVERT, 2'd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b1);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, Q_ONE, 2 * Q_ONE, 3 * Q_ONE, Q_ONE, 1'b0);
      // inverse translation that saturates
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd3, E_MAX, E_MAX, E_MAX, Q_ONE, 1'b0);
      queue_vertex(mvt_pkg::MODE_LOAD, 2'd0, E_MAX, E_MAX, E_MAX, 32'sd0, 1'b0);
      queue_vertex(mvt_pkg::MODE_INVERT, 2'd3, E_MIN, E_MAX, E_MIN, E_MAX, 1'b0);
      queue_vertex(mvt_pkg::MODE_XFORM, 2'd0, 32'sd0, 32'sd0, 32'sd0, Q_ONE, 1'b0);

      count = 0;
      while (count < RANDOM_ITEMS) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               queue_vertex(mvt_pkg::MODE_XFORM, 2'($urandom), rand_elem(), rand_elem(),
                            rand_elem(), rand_elem(), $urandom_range(99) == 0);
            end
            count += burst;
         end else if (pick < 72) begin
            for (r = 0; r < 4; r++) begin
               queue_vertex(mvt_pkg::MODE_LOAD, r[1:0], rand_elem(), rand_elem(),
                            rand_elem(), (r == 3) ? Q_ONE : rand_elem(), 1'b0);
            end
            count += 4;
            if ($urandom_range(1) == 1) begin
               queue_vertex(mvt_pkg::MODE_INVERT, 2'($urandom), rand_elem(), rand_elem(),
                            rand_elem(), rand_elem(), $urandom_range(9) == 0);
               count++;
            end
         end else if (pick < 84) begin
            queue_vertex(mvt_pkg::MODE_LOAD, 2'($urandom), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), 1'b0);
            count++;
         end else if (pick < 93) begin
            queue_vertex(mvt_pkg::MODE_INVERT, 2'($urandom), rand_elem(), rand_elem(),
                         rand_elem(), rand_elem(), 1'b0);
            count++;
         end else begin
            // noise: unused mode
            queue_vertex(MODE_UNUSED, 2'($urandom), rand_elem(), rand_elem(), rand_elem(),
                         rand_elem(), 1'b0);
         end
      end
      n_items = vertex_backlog.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (!(items_taken == n_items && results_due == results_seen)) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0 && transformed_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
design/mvt_pkg.sv
design/mvt_if.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/mvt_matrix.sv
design/matrix_vector_transform.sv
test/matrix_vector_transform_test.sv
